[hdl/rce_pkg.sv]
// ----------------------------------------------------------------------------
// rce_pkg
// shared types, constants and codes of the roberts cross edge block
// ----------------------------------------------------------------------------
package rce_pkg;

	// default size limits
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// field widths
	localparam int PIXEL_W     = 8;
	localparam int EDGE_W      = 8;
	localparam int ROW_OUT_W   = 12;
	localparam int COL_OUT_W   = 10;
	localparam int S_TDATA_W   = 8;
	localparam int M_TDATA_W   = 32;
	localparam int M_TUSER_W   = 1;
	localparam int M_PAD_W     = M_TDATA_W - EDGE_W - ROW_OUT_W - COL_OUT_W;

	// configuration port
	localparam int MODE_W       = 2;
	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	// output modes, the unused code behaves as magnitude
	localparam logic [MODE_W-1:0] MODE_DIAG1 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DIAG2 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MAG   = 2'd2;

	localparam logic [MODE_W-1:0]       MODE_RESET   = MODE_MAG;
	localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;

	// gradients and root unit
	localparam int GRAD_W     = PIXEL_W + 1;
	localparam int SQ_W       = 2 * PIXEL_W;
	localparam int SUM_W      = SQ_W + 1;
	localparam int RAD_W      = 18;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int ROOT_STEPS = RAD_W / 2;
	localparam int NUM_SLOTS  = 4;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_PUSH,
		ST_COMMIT
	} rce_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load;
		logic square;
		logic sum;
		logic root_go;
		logic push;
		logic commit;
	} rce_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pending_any;
		logic pending_more;
		logic mode_root;
		logic root_done;
		logic out_free;
	} rce_status_t;

endpackage

[hdl/rce_ram.sv]
// ----------------------------------------------------------------------------
// rce_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/rce_isqrt.sv]
// ----------------------------------------------------------------------------
// rce_isqrt
// bit-pair square root, one root bit per cycle, rounded and saturated result
// ----------------------------------------------------------------------------
module rce_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rce_pkg::RAD_W-1:0]  radicand,
	output logic                       done,
	output logic [rce_pkg::EDGE_W-1:0] root
);

	import rce_pkg::*;

	localparam int CNT_W   = $clog2(ROOT_STEPS + 1);
	localparam int REM_W   = ROOT_W + 2;
	localparam int TRIAL_W = REM_W + 2;

	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [RAD_W-1:0]   rad_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [TRIAL_W-1:0] rem_sh;
	logic [TRIAL_W-1:0] trial;
	logic               ge;
	logic [ROOT_W:0]    rounded;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(ROOT_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one trial subtraction per step
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	// round up when the remainder passes the root, then saturate
	assign rounded = {1'b0, root_q} + ((rem_q > {2'b00, root_q}) ? (ROOT_W+1)'(1) : '0);
	assign root    = (rounded > (ROOT_W+1)'(255)) ? '1 : rounded[EDGE_W-1:0];
	assign done    = done_q;

endmodule

[hdl/rce_dpath.sv]
// ----------------------------------------------------------------------------
// rce_dpath
// counters, line store, neighbor window, gradients, root unit and output beat
// ----------------------------------------------------------------------------
module rce_dpath #(
	parameter int MAX_WIDTH  = rce_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rce_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rce_pkg::rce_cmd_t              cmd,
	output rce_pkg::rce_status_t           status,
	input  logic                           cfg_valid,
	input  logic [rce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [rce_pkg::PIXEL_W-1:0]    pixel,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [rce_pkg::EDGE_W-1:0]     edge_value,
	output logic [rce_pkg::ROW_OUT_W-1:0]  out_row,
	output logic [rce_pkg::COL_OUT_W-1:0]  out_col,
	output logic                           frame_done,
	output logic                           last_in_run
);

	import rce_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
	localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

	function automatic logic signed [GRAD_W-1:0] diff(input logic [PIXEL_W-1:0] a,
		input logic [PIXEL_W-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic [EDGE_W-1:0] abs_sat(input logic signed [GRAD_W-1:0] g);
		logic [GRAD_W-1:0] a;
		a = (g < 0) ? GRAD_W'(-g) : GRAD_W'(g);
		return a[GRAD_W-1] ? '1 : a[EDGE_W-1:0];
	endfunction

	// configuration registers
	logic [MODE_W-1:0]       mode_q;
	logic [CFG_WIDTH_W-1:0]  width_q;
	logic [CFG_HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OUTPUT_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size and current position
	logic [WCNT_W-1:0] w_eff;
	logic [HCNT_W-1:0] h_eff;
	logic [COL_W-1:0]  col_q, c_eff;
	logic [ROW_W-1:0]  row_q, r_eff;
	logic              c_last, r_last;

	always_comb begin
		if (32'(width_q) < 32'd2) begin
			w_eff = WCNT_W'(2);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			w_eff = WCNT_W'(width_q);
		end
		if (32'(height_q) < 32'd2) begin
			h_eff = HCNT_W'(2);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HCNT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HCNT_W'(height_q);
		end
		c_eff  = (32'(col_q) >= 32'(w_eff)) ? '0 : col_q;
		r_eff  = (32'(row_q) >= 32'(h_eff)) ? '0 : row_q;
		c_last = (32'(c_eff) + 32'd1 == 32'(w_eff));
		r_last = (32'(r_eff) + 32'd1 == 32'(h_eff));
	end

	// per-pixel context captured on the input beat
	logic [PIXEL_W-1:0]   v_q;
	logic [COL_W-1:0]     c_q;
	logic [ROW_W-1:0]     r_q;
	logic                 c_one_q;
	logic                 c_last_q;
	logic                 last_row_q;
	logic [NUM_SLOTS-1:0] pend_q;
	logic [NUM_SLOTS-1:0] cur_q;
	logic                 any_res;

	assign any_res = (r_eff != '0) && (c_eff != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			cur_q  <= '0;
		end else begin
			if (cmd.take) begin
				pend_q <= {any_res && c_last && r_last, any_res && c_last,
					any_res && r_last, any_res};
				if (c_last) begin
					col_q <= '0;
					row_q <= r_last ? '0 : ROW_W'(32'(r_eff) + 32'd1);
				end else begin
					col_q <= COL_W'(32'(c_eff) + 32'd1);
					row_q <= r_eff;
				end
			end else if (cmd.push) begin
				pend_q <= pend_q & ~cur_q;
			end
			if (cmd.load) begin
				cur_q <= pend_q & (~pend_q + NUM_SLOTS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			v_q        <= pixel;
			c_q        <= c_eff;
			r_q        <= r_eff;
			c_one_q    <= (32'(c_eff) == 32'd1);
			c_last_q   <= c_last;
			last_row_q <= r_last;
		end
	end

	// line store holding the row above
	logic [PIXEL_W-1:0] t2;

	rce_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (c_q),
		.wdata (v_q),
		.re    (cmd.take),
		.raddr (c_eff),
		.rdata (t2)
	);

	// neighbor window, shifted once the pixel is done
	logic [PIXEL_W-1:0] cw0_q, cw1_q, pw0_q, pw1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw0_q <= '0;
			cw1_q <= '0;
			pw0_q <= '0;
			pw1_q <= '0;
		end else if (cmd.commit) begin
			cw0_q <= cw1_q;
			cw1_q <= v_q;
			pw0_q <= pw1_q;
			pw1_q <= t2;
		end
	end

	// gradients and tags of the lowest pending result
	logic [NUM_SLOTS-1:0]            sel;
	logic [PIXEL_W-1:0]              side, up;
	logic signed [GRAD_W-1:0]        g1_n, g2_n;
	logic [ROW_W-1:0]                rm1;
	logic [COL_W-1:0]                cm1;
	logic [ROW_OUT_W-1:0]            row_n;
	logic [COL_OUT_W-1:0]            col_n;

	assign sel  = pend_q & (~pend_q + NUM_SLOTS'(1));
	assign side = c_one_q ? v_q : cw0_q;
	assign up   = c_one_q ? t2 : pw0_q;
	assign rm1  = r_q - ROW_W'(1);
	assign cm1  = c_q - COL_W'(1);

	always_comb begin
		if (sel[0]) begin
			g1_n  = diff(v_q, pw1_q);
			g2_n  = diff(side, pw1_q);
			row_n = ROW_OUT_W'(32'(rm1));
			col_n = COL_OUT_W'(32'(cm1));
		end else if (sel[1]) begin
			g1_n  = diff(t2, cw1_q);
			g2_n  = diff(up, cw1_q);
			row_n = ROW_OUT_W'(32'(r_q));
			col_n = COL_OUT_W'(32'(cm1));
		end else if (sel[2]) begin
			g1_n  = diff(cw1_q, t2);
			g2_n  = g1_n;
			row_n = ROW_OUT_W'(32'(rm1));
			col_n = COL_OUT_W'(32'(c_q));
		end else begin
			g1_n  = diff(pw1_q, v_q);
			g2_n  = g1_n;
			row_n = ROW_OUT_W'(32'(r_q));
			col_n = COL_OUT_W'(32'(c_q));
		end
	end

	logic signed [GRAD_W-1:0] g1_q, g2_q;
	logic [ROW_OUT_W-1:0]     tag_row_q;
	logic [COL_OUT_W-1:0]     tag_col_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			g1_q      <= g1_n;
			g2_q      <= g2_n;
			tag_row_q <= row_n;
			tag_col_q <= col_n;
		end
	end

	// shared squarer, then sum of squares
	logic signed [GRAD_W-1:0]   mul_a;
	logic signed [2*GRAD_W-1:0] prod;
	logic [SQ_W-1:0]            sq_q;
	logic [SUM_W-1:0]           sum_q;

	assign mul_a = cmd.square ? g1_q : g2_q;
	assign prod  = mul_a * mul_a;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sq_q <= prod[SQ_W-1:0];
		end
		if (cmd.sum) begin
			sum_q <= {1'b0, sq_q} + {1'b0, prod[SQ_W-1:0]};
		end
	end

	// rounded magnitude
	logic               root_done;
	logic [EDGE_W-1:0]  root_val;

	rce_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_go),
		.radicand (RAD_W'(sum_q)),
		.done     (root_done),
		.root     (root_val)
	);

	// edge value by mode
	logic              mode_root;
	logic [EDGE_W-1:0] edge_n;
	logic              more;

	assign mode_root = !(mode_q == MODE_DIAG1 || mode_q == MODE_DIAG2);
	assign edge_n    = mode_root ? root_val :
		((mode_q == MODE_DIAG2) ? abs_sat(g2_q) : abs_sat(g1_q));
	assign more      = |(pend_q & ~cur_q);

	// output register
	logic              out_valid_q;
	logic [EDGE_W-1:0] edge_q;
	logic [ROW_OUT_W-1:0] orow_q;
	logic [COL_OUT_W-1:0] ocol_q;
	logic              frame_q;
	logic              olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			edge_q  <= edge_n;
			orow_q  <= tag_row_q;
			ocol_q  <= tag_col_q;
			olast_q <= !more;
			frame_q <= !more && last_row_q && c_last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign edge_value  = edge_q;
	assign out_row     = orow_q;
	assign out_col     = ocol_q;
	assign frame_done  = frame_q;
	assign last_in_run = olast_q;

	// status to the controller
	always_comb begin
		status.pending_any  = |pend_q;
		status.pending_more = more;
		status.mode_root    = mode_root;
		status.root_done    = root_done;
		status.out_free     = !out_valid_q || out_ready;
	end

endmodule

[hdl/rce_ctrl.sv]
// ----------------------------------------------------------------------------
// rce_ctrl
// sequencer: takes one pixel, walks its results, then updates the window
// ----------------------------------------------------------------------------
module rce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rce_pkg::rce_status_t status,
	output rce_pkg::rce_cmd_t    cmd
);

	import rce_pkg::*;

	rce_state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_n = ST_FETCH;
			end
			ST_FETCH: begin
				state_n = status.pending_any ? ST_LOAD : ST_COMMIT;
			end
			ST_LOAD: begin
				state_n = status.mode_root ? ST_SQUARE : ST_PUSH;
			end
			ST_SQUARE:  state_n = ST_SUM;
			ST_SUM:     state_n = ST_ROOT_GO;
			ST_ROOT_GO: state_n = ST_ROOT_WAIT;
			ST_ROOT_WAIT: begin
				if (status.root_done) state_n = ST_PUSH;
			end
			ST_PUSH: begin
				if (status.out_free) begin
					state_n = status.pending_more ? ST_LOAD : ST_COMMIT;
				end
			end
			ST_COMMIT: state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_LOAD:    cmd.load    = 1'b1;
			ST_SQUARE:  cmd.square  = 1'b1;
			ST_SUM:     cmd.sum     = 1'b1;
			ST_ROOT_GO: cmd.root_go = 1'b1;
			ST_PUSH:    cmd.push    = status.out_free;
			ST_COMMIT:  cmd.commit  = 1'b1;
			default: ;
		endcase
	end

endmodule

[hdl/roberts_cross_edge.sv]
// ----------------------------------------------------------------------------
// roberts_cross_edge
// roberts cross edge detector on a raster stream of 8-bit grey pixels
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the slave stream; each pixel p(y,x) of a
// frame yields one edge beat tagged with its row and column, computed from
// g1 = p(y+1,x+1) - p(y,x) and g2 = p(y+1,x-1) - p(y,x) with reflected borders.
// Row y is finished while row y+1 streams in; the last row is finished
// interleaved with the row above it, so one pixel gives zero to four beats.
// Mode 0 gives |g1|, mode 1 |g2|, mode 2 (and 3) the rounded magnitude, all
// saturated to 255. A pixel is taken, then each of its results is loaded
// and pushed, in magnitude mode after square, sum and the root unit that
// resolves one bit of the 9-bit root per cycle; a push waits for the
// output register to free. A result waiting there does not stop the next
// pixel being taken. The line store is a ram of MAX_WIDTH pixels; tdata
// on the master side is {pad, out_col, out_row, edge_value} and tlast marks
// the last beat caused by one pixel, tuser the last beat of the frame.
module roberts_cross_edge #(
	parameter int MAX_WIDTH  = rce_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rce_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input pixel stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [rce_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel
	// edge result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [rce_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [7:0] edge_value,
	                                                        // [19:8] out_row,
	                                                        // [29:20] out_col
	output logic                            m_axis_tlast,   // last_in_run
	output logic [rce_pkg::M_TUSER_W-1:0]   m_axis_tuser,   // [0] frame_done
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rce_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import rce_pkg::*;

	rce_cmd_t    cmd;
	rce_status_t status;

	logic [EDGE_W-1:0]    edge_value;
	logic [ROW_OUT_W-1:0] out_row;
	logic [COL_OUT_W-1:0] out_col;
	logic                 frame_done;
	logic                 last_in_run;

	// sequencer
	rce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	rce_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel       (s_axis_tdata[PIXEL_W-1:0]),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.edge_value  (edge_value),
		.out_row     (out_row),
		.out_col     (out_col),
		.frame_done  (frame_done),
		.last_in_run (last_in_run)
	);

	// registers are always writable
	assign cfg_ready = 1'b1;

	// pack the result beat
	assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_col, out_row, edge_value};
	assign m_axis_tlast = last_in_run;
	assign m_axis_tuser = M_TUSER_W'(frame_done);

endmodule

[hdl/rce_checker.sv]
// ----------------------------------------------------------------------------
// rce_checker
// port-level checks of the edge block, bound to the top level
// ----------------------------------------------------------------------------
module rce_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [rce_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic [rce_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

	import rce_pkg::*;

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// end of frame is always the last beat of its pixel
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("frame end without last beat");

	// one pixel at a time: no input taken right after an input beat
	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on back to back cycles");

	// tdata padding stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1 -: M_PAD_W] == '0))
		else $error("tdata padding not zero");

endmodule

bind roberts_cross_edge rce_checker u_rce_checker (.*);

[tb/sv/roberts_cross_edge_checker.sv]
// ----------------------------------------------------------------------------
// roberts_cross_edge_checker
// scoreboard for the roberts cross edge detector
// ----------------------------------------------------------------------------
// Watches the pixel, edge and configuration channels. It keeps its own copy
// of the configuration, the line store, the neighbor windows and the raster
// counters, works out the edge beats that every accepted pixel causes and
// compares each accepted edge beat field by field with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roberts_cross_edge_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [rce_pkg::S_TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [rce_pkg::M_TDATA_W-1:0]   m_axis_tdata,   // [7:0] edge_value,
	                                                        // [19:8] out_row,
	                                                        // [29:20] out_col
	input  logic                            m_axis_tlast,   // last_in_run
	input  logic [rce_pkg::M_TUSER_W-1:0]   m_axis_tuser,   // [0] frame_done
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rce_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rce_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              error_count,
	output int                              beats_pending
);
	import rce_pkg::*;

	localparam int LINE_DEPTH = DEF_MAX_WIDTH;

	typedef struct packed {
		logic [EDGE_W-1:0]    edge_value;
		logic [ROW_OUT_W-1:0] out_row;
		logic [COL_OUT_W-1:0] out_col;
		logic                 frame_done;
		logic                 last_in_run;
	} edge_beat_t;

	// shadow state of the detector
	logic [PIXEL_W-1:0]      line_store [LINE_DEPTH];
	logic [PIXEL_W-1:0]      cur_win [2];
	logic [PIXEL_W-1:0]      up_win [3];
	int unsigned             col_cnt;
	int unsigned             row_cnt;
	logic [MODE_W-1:0]       mode;
	logic [CFG_WIDTH_W-1:0]  width_reg;
	logic [CFG_HEIGHT_W-1:0] height_reg;

	edge_beat_t edge_queue [$];
	int         errors;

	// absolute value clipped to the pixel range
	function automatic int unsigned abs_clip(input int g);
		int unsigned a;
		a = (g < 0) ? -g : g;
		return (a > 255) ? 255 : a;
	endfunction

	// integer square root rounded to nearest
	function automatic int unsigned rounded_root(input int unsigned s);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= s)
			r++;
		if (s > r * r + r)
			r++;
		return r;
	endfunction

	function automatic logic [EDGE_W-1:0] edge_strength(input int g1, input int g2);
		int unsigned m;
		case (mode)
			MODE_DIAG1: m = abs_clip(g1);
			MODE_DIAG2: m = abs_clip(g2);
			default:    m = rounded_root(g1 * g1 + g2 * g2);
		endcase
		if (m > 255)
			m = 255;
		return m[EDGE_W-1:0];
	endfunction

	function automatic edge_beat_t beat_at(input logic [EDGE_W-1:0] value,
		input int unsigned row, input int unsigned col);
		edge_beat_t b;
		b.edge_value  = value;
		b.out_row     = ROW_OUT_W'(row);
		b.out_col     = COL_OUT_W'(col);
		b.frame_done  = 1'b0;
		b.last_in_run = 1'b0;
		return b;
	endfunction

	// edge beats caused by one pixel, then the window and counter update
	task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
		int unsigned w, h, r, c;
		int          v, t0, t1, t2, b0, b1, side, up;
		bit          last_row;
		edge_beat_t  beats [4];
		int          n, k;
		w = width_reg;
		h = height_reg;
		if (w < 2) w = 2;
		if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
		if (h < 2) h = 2;
		if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
		// a bound lowered below the counters restarts them
		if (col_cnt >= w) col_cnt = 0;
		if (row_cnt >= h) row_cnt = 0;
		r = row_cnt;
		c = col_cnt;
		v = px;
		up_win[2] = line_store[c];
		t0 = up_win[0];
		t1 = up_win[1];
		t2 = up_win[2];
		b0 = cur_win[0];
		b1 = cur_win[1];
		last_row = (r == h - 1);
		n = 0;
		if (r >= 1 && c >= 1) begin
			// left border reflects onto column 1
			side = (c == 1) ? v : b0;
			beats[n] = beat_at(edge_strength(v - t1, side - t1), r - 1, c - 1);
			n++;
			if (last_row) begin
				up = (c == 1) ? t2 : t0;
				beats[n] = beat_at(edge_strength(t2 - b1, up - b1), r, c - 1);
				n++;
			end
			// right border reflects onto column w-2
			if (c == w - 1) begin
				beats[n] = beat_at(edge_strength(b1 - t2, b1 - t2), r - 1, c);
				n++;
				if (last_row) begin
					beats[n] = beat_at(edge_strength(t1 - v, t1 - v), r, c);
					n++;
				end
			end
		end
		if (n > 0) begin
			beats[n - 1].last_in_run = 1'b1;
			if (last_row && c == w - 1)
				beats[n - 1].frame_done = 1'b1;
		end
		for (k = 0; k < n; k++)
			edge_queue.push_back(beats[k]);

		line_store[c] = px;
		cur_win[0] = cur_win[1];
		cur_win[1] = px;
		up_win[0] = up_win[1];
		up_win[1] = up_win[2];
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endtask

	// watch all three channels
	always @(posedge clk or negedge arst_n) begin
		edge_beat_t got;
		edge_beat_t want;
		if (!arst_n) begin
			for (int i = 0; i < LINE_DEPTH; i++)
				line_store[i] = '0;
			cur_win[0] = '0;
			cur_win[1] = '0;
			up_win[0] = '0;
			up_win[1] = '0;
			up_win[2] = '0;
			col_cnt = 0;
			row_cnt = 0;
			mode = MODE_RESET;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			edge_queue.delete();
			errors = 0;
			error_count <= 0;
			beats_pending <= 0;
		end else begin
			// register write beat
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OUTPUT_MODE:  mode = cfg_data[MODE_W-1:0];
					CFG_IMAGE_WIDTH:  width_reg = cfg_data[CFG_WIDTH_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_data[CFG_HEIGHT_W-1:0];
					default: ;
				endcase
			end
			// pixel beat
			if (s_axis_tvalid && s_axis_tready)
				predict_pixel(s_axis_tdata[PIXEL_W-1:0]);
			// edge beat
			if (m_axis_tvalid && m_axis_tready) begin
				got.edge_value  = m_axis_tdata[EDGE_W-1:0];
				got.out_row     = m_axis_tdata[EDGE_W +: ROW_OUT_W];
				got.out_col     = m_axis_tdata[EDGE_W + ROW_OUT_W +: COL_OUT_W];
				got.frame_done  = m_axis_tuser[0];
				got.last_in_run = m_axis_tlast;
				if (edge_queue.size() == 0) begin
					$error("edge beat with nothing due: row %0d col %0d value %0d",
						got.out_row, got.out_col, got.edge_value);
					errors++;
				end else begin
					want = edge_queue.pop_front();
					check_field("edge_value", want.edge_value, got.edge_value);
					check_field("out_row", want.out_row, got.out_row);
					check_field("out_col", want.out_col, got.out_col);
					check_field("frame_done", want.frame_done, got.frame_done);
					check_field("last_in_run", want.last_in_run, got.last_in_run);
				end
			end
			error_count <= errors;
			beats_pending <= edge_queue.size();
		end
	end

endmodule

[tb/sv/roberts_cross_edge_test.sv]
// ----------------------------------------------------------------------------
// roberts_cross_edge_test
// stimulus and verdict for the roberts cross edge detector
// ----------------------------------------------------------------------------
// Streams frames of grey pixels into the block under several modes and frame
// sizes: a check of the reset settings, short directed frames with extreme
// pixels and border cases, bounds lowered mid-frame, random frames with
// random stalls on both streams and one long output hold-off, and finally
// sizes above the limits that get clamped, closed early by lowered bounds.
// The checker module predicts and compares; this module only drives the
// channels and reports the outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roberts_cross_edge_test;
	import rce_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;
	localparam int SETTLE_CYCLES    = 80;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int RANDOM_PIXELS    = 120;

	typedef enum int {
		PIX_RANDOM,
		PIX_EXTREME,
		PIX_RAMP,
		PIX_FLAT,
		PIX_CHECKER,
		PIX_ROWS
	} pixel_kind_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   m_axis_tlast;
	logic [M_TUSER_W-1:0]   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	int                     error_count;
	int                     beats_pending;

	// stall control
	bit idling_on = 1'b1;
	bit long_hold_go = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;
	int ready_left = 0;

	// raster position of the next pixel, for ending frames cleanly
	logic [CFG_WIDTH_W-1:0]  width_raw = WIDTH_RESET;
	logic [CFG_HEIGHT_W-1:0] height_raw = HEIGHT_RESET;
	int unsigned             pos_col = 0;
	int unsigned             pos_row = 0;
	int unsigned             pixels_sent = 0;

	roberts_cross_edge dut (.*);

	roberts_cross_edge_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// overall time limit
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	// edge receiver: random ready bursts and one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (long_hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= LONG_HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (!idling_on) begin
			m_axis_tready <= 1'b1;
		end else if (ready_left > 0) begin
			ready_left <= ready_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 2) != 0);
			ready_left <= $urandom_range(0, 15);
		end
	end

	function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned hi);
		if (raw < 2)
			return 2;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	function automatic bit at_frame_start();
		int unsigned w, h;
		w = clamp_size(width_raw, DEF_MAX_WIDTH);
		h = clamp_size(height_raw, DEF_MAX_HEIGHT);
		return (pos_col == 0 || pos_col >= w) && (pos_row == 0 || pos_row >= h);
	endfunction

	function automatic logic [PIXEL_W-1:0] pick_pixel(input pixel_kind_t kind);
		case (kind)
			PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			PIX_RAMP:    return PIXEL_W'(pos_col * 23 + pos_row * 41 + $urandom_range(0, 3));
			PIX_FLAT:    return 8'd137;
			PIX_CHECKER: return ((pos_col + pos_row) % 2 == 1) ? 8'hFF : 8'h00;
			PIX_ROWS:    return (pos_row % 2 == 0) ? 8'hFF : 8'h00;
			default:     return PIXEL_W'($urandom);
		endcase
	endfunction

	// one pixel beat, with an optional gap ahead of it
	task automatic send_pixel(input logic [PIXEL_W-1:0] px);
		int unsigned w, h;
		w = clamp_size(width_raw, DEF_MAX_WIDTH);
		h = clamp_size(height_raw, DEF_MAX_HEIGHT);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pixels_sent++;
		if (pos_col >= w) pos_col = 0;
		if (pos_row >= h) pos_row = 0;
		if (pos_col + 1 >= w) begin
			pos_col = 0;
			pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
		end else begin
			pos_col++;
		end
	endtask

	task automatic send_count(input pixel_kind_t kind, input int unsigned n);
		repeat (n) send_pixel(pick_pixel(kind));
	endtask

	// pixels up to the start of the next frame
	task automatic send_frame(input pixel_kind_t kind);
		do
			send_pixel(pick_pixel(kind));
		while (!at_frame_start());
	endtask

	// stop the pixel stream and let every due edge beat come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (beats_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high so that writes can follow back to back
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_IMAGE_WIDTH:  width_raw = data[CFG_WIDTH_W-1:0];
			CFG_IMAGE_HEIGHT: height_raw = data[CFG_HEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [MODE_W-1:0] m, input int unsigned w,
		input int unsigned h);
		write_reg(CFG_OUTPUT_MODE, {11'($urandom), m});
		write_reg(CFG_IMAGE_WIDTH, {2'($urandom), CFG_WIDTH_W'(w)});
		write_reg(CFG_IMAGE_HEIGHT, CFG_HEIGHT_W'(h));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned w, h, phase, first;
		pixel_kind_t kind;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a few pixels in magnitude mode, then both bounds
		// lowered mid-frame to close the frame early
		send_count(PIX_RANDOM, 6);
		drain();
		write_reg(CFG_IMAGE_WIDTH, {2'b00, 11'd8});
		write_reg(CFG_IMAGE_HEIGHT, 13'd2);
		cfg_valid <= 1'b0;
		send_frame(PIX_RANDOM);

		// magnitude mode on a checkerboard, where both diagonals are flat
		drain();
		configure(MODE_MAG, 3, 3);
		send_frame(PIX_CHECKER);

		// negative full-scale gradients on each diagonal
		drain();
		configure(MODE_DIAG1, 2, 2);
		send_frame(PIX_ROWS);
		drain();
		configure(MODE_DIAG2, 3, 2);
		send_frame(PIX_ROWS);

		// unused mode code, sizes below the minimum, spare register index
		drain();
		write_reg(CFG_SPARE, 13'h1FFF);
		configure(MODE_SPARE, 1, 0);
		send_frame(PIX_EXTREME);

		// width lowered below the column count, then height below the row count
		drain();
		configure(MODE_DIAG2, 6, 5);
		send_count(PIX_RANDOM, 16);
		drain();
		write_reg(CFG_IMAGE_WIDTH, {2'b11, 11'd3});
		cfg_valid <= 1'b0;
		send_count(PIX_RANDOM, 4);
		drain();
		write_reg(CFG_IMAGE_HEIGHT, 13'd2);
		cfg_valid <= 1'b0;
		send_frame(PIX_RAMP);

		// random frames, mostly small
		first = pixels_sent;
		phase = 0;
		while (pixels_sent - first < RANDOM_PIXELS || phase < 2) begin
			drain();
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 32) : $urandom_range(2, 8);
			h = $urandom_range(2, 5);
			if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1);
			if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1);
			if (phase == 1) begin
				// output held off while a busy frame streams in
				w = 16;
				h = 4;
				long_hold_go <= 1'b1;
			end
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
			configure(MODE_W'($urandom_range(0, 3)), w, h);
			kind = pixel_kind_t'($urandom_range(0, 3));
			repeat ($urandom_range(1, 2)) send_frame(kind);
			if ($urandom_range(0, 3) == 0) begin
				w = clamp_size(width_raw, DEF_MAX_WIDTH);
				h = clamp_size(height_raw, DEF_MAX_HEIGHT);
				send_count(kind, $urandom_range(1, w * h - 1));
				drain();
				if ($urandom_range(0, 1) == 0)
					write_reg(CFG_IMAGE_WIDTH, {2'($urandom), 11'($urandom_range(2, w))});
				else
					write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(2, h)));
				cfg_valid <= 1'b0;
				send_frame(kind);
			end
			phase++;
		end

		// sizes above the limits, no stalls: clamped width, then clamped
		// height, each frame closed early by a lowered bound
		drain();
		idling_on <= 1'b0;
		configure(MODE_MAG, 2047, 2);
		send_count(PIX_RANDOM, 6);
		drain();
		write_reg(CFG_IMAGE_WIDTH, {2'b00, 11'd8});
		cfg_valid <= 1'b0;
		send_frame(PIX_RANDOM);
		drain();
		configure(MODE_DIAG1, 0, 8191);
		send_count(PIX_EXTREME, 6);
		drain();
		write_reg(CFG_IMAGE_HEIGHT, 13'd4);
		cfg_valid <= 1'b0;
		send_frame(PIX_EXTREME);

		drain();
		if (error_count == 0 && beats_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
